// File: hw/rtl/pmp_pkg.sv
// shared types and constants for the paged memory protection unit
// no dependencies
`default_nettype none

package pmp_pkg;

    localparam int NUM_PAGES  = 16;
    localparam int PAGE_BYTES = 4096;
    localparam int IDX_W      = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int OFF_W      = $clog2(PAGE_BYTES);
    localparam int PN_W       = 32 - OFF_W;
    localparam int ROW_W      = IDX_W + OFF_W - 2;
    localparam int BANK_ROWS  = NUM_PAGES * PAGE_BYTES / 4;

    localparam logic [31:0] CONSOLE_ADDR = 32'h0000_00A0;
    localparam logic [31:0] INPUT_ADDR   = 32'h0000_00A4;

    typedef enum logic [3:0] {
        OP_RD_BYTE  = 4'd0,
        OP_RD_WORD  = 4'd1,
        OP_RD_DWORD = 4'd2,
        OP_FETCH    = 4'd3,
        OP_WR_BYTE  = 4'd4,
        OP_WR_WORD  = 4'd5,
        OP_WR_DWORD = 4'd6,
        OP_MAP      = 4'd7,
        OP_UNMAP    = 4'd8
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FAULT    = 2'd1,
        ST_NO_WRITE = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef struct packed {
        logic [3:0]  op;
        logic [31:0] address;
        logic [31:0] write_data;
        logic [1:0]  page_flags;
    } t_in_item;

    typedef struct packed {
        logic [31:0] read_data;
        logic [1:0]  status;
        logic        console_valid;
        logic [7:0]  console_char;
        logic        input_read_event;
    } t_out_item;

    // classified access handed from front to back, vector fields we, row and wdata indexed by bank
    typedef struct packed {
        logic                  rd;
        logic [3:0]            we;
        logic [3:0][ROW_W-1:0] row;
        logic [3:0][7:0]       wdata;
        logic [1:0]            off;
        logic [3:0]            keep;
        t_status               status;
        logic                  cvalid;
        logic [7:0]            cchar;
        logic                  ievent;
    } t_cmd;

endpackage

`default_nettype wire

// File: hw/rtl/pmp_if.sv
// valid/ready channel interfaces for input and result items
// depends on pmp_pkg
`default_nettype none

interface pmp_in_if;
    import pmp_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pmp_out_if;
    import pmp_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/paged_memory_with_permissions_core.sv
// Paged memory protection unit: a 16-entry page table looked up associatively and a
// byte-addressed store of four byte-wide banks. One access is taken per clock when the
// result side keeps up; a result is offered once its access has passed the queue and the
// result register, and the two-entry queue between front and back lets up to two further
// accesses be taken while a result is held. The rate is set by the banks, which give one
// read or one write each per cycle, so any aligned or page-crossing access of up to four
// bytes touches each bank at most once. Page table updates (map, unmap all) take effect
// for the very next access. Bytes of a freshly mapped page read as undefined until
// written.
// depends on pmp_pkg, pmp_if, pmp_front, pmp_queue, pmp_back
`default_nettype none

module paged_memory_with_permissions_core (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pmp_in_if.sink    i_in,
    pmp_out_if.source o_out
);
    import pmp_pkg::*;

    t_cmd front_cmd, q_cmd;
    logic q_full, q_valid, pop, fire;

    assign i_in.ready = !q_full;
    assign fire       = i_in.valid && !q_full;

    pmp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (i_in.data),
        .o_cmd   (front_cmd)
    );

    pmp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    pmp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_cmd   (q_cmd),
        .o_pop   (pop),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_item  (o_out.data)
    );

endmodule

`default_nettype wire

// File: hw/rtl/pmp_front.sv
// front end: page table, lookup of both touched pages, access classification
// depends on pmp_pkg
`default_nettype none

module pmp_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_fire,
    input  wire pmp_pkg::t_in_item i_item,
    output pmp_pkg::t_cmd         o_cmd
);
    import pmp_pkg::*;

    logic [NUM_PAGES-1:0] r_valid;
    logic [PN_W-1:0]      r_pn [NUM_PAGES];
    logic [NUM_PAGES-1:0] r_w;
    logic [NUM_PAGES-1:0] r_x;

    logic [PN_W-1:0]  pn0, pn1;
    logic             h0, h1, hf;
    logic [IDX_W-1:0] e0, e1, ef;
    logic [3:0]       hit, exe, nmask;
    logic [IDX_W-1:0] ent [4];
    logic [31:0]      abyte [4];
    logic [OFF_W:0]   osum;
    logic             fault_any, xfault_any, later_miss;
    logic [1:0]       bi;
    t_cmd             cmd;

    always_comb begin
        pn0 = i_item.address[31:OFF_W];
        pn1 = pn0 + 1'b1;
        h0 = 1'b0; h1 = 1'b0; hf = 1'b0;
        e0 = '0; e1 = '0; ef = '0;
        for (int k = NUM_PAGES - 1; k >= 0; k--) begin
            if (r_valid[k] && r_pn[k] == pn0) begin
                h0 = 1'b1;
                e0 = IDX_W'(k);
            end
            if (r_valid[k] && r_pn[k] == pn1) begin
                h1 = 1'b1;
                e1 = IDX_W'(k);
            end
            if (!r_valid[k]) begin
                hf = 1'b1;
                ef = IDX_W'(k);
            end
        end
        // each byte sits in the first page or, past a boundary, the next one
        for (int i = 0; i < 4; i++) begin
            osum     = {1'b0, i_item.address[OFF_W-1:0]} + (OFF_W+1)'(i);
            abyte[i] = i_item.address + 32'(i);
            hit[i]   = osum[OFF_W] ? h1 : h0;
            ent[i]   = osum[OFF_W] ? e1 : e0;
            exe[i]   = r_x[ent[i]];
        end
        case (i_item.op)
            OP_RD_BYTE, OP_WR_BYTE: nmask = 4'b0001;
            OP_RD_WORD, OP_WR_WORD: nmask = 4'b0011;
            default:                nmask = 4'b1111;
        endcase
        fault_any  = |(nmask & ~hit);
        xfault_any = |(nmask & ~exe);
        later_miss = |(nmask & ~hit & 4'b1110);

        cmd        = '0;
        cmd.off    = i_item.address[1:0];
        cmd.keep   = nmask;
        for (int k = 0; k < 4; k++) begin
            bi = 2'(k) - i_item.address[1:0];
            cmd.row[k]   = {ent[bi], abyte[bi][OFF_W-1:2]};
            cmd.wdata[k] = i_item.write_data[8*bi +: 8];
        end
        unique case (i_item.op)
            OP_RD_BYTE, OP_RD_WORD, OP_RD_DWORD, OP_FETCH: begin
                if (fault_any || (i_item.op == OP_FETCH && xfault_any))
                    cmd.status = ST_FAULT;
                else
                    cmd.rd = 1'b1;
                cmd.ievent = (i_item.op == OP_RD_BYTE) && (i_item.address == INPUT_ADDR);
            end
            OP_WR_BYTE, OP_WR_WORD, OP_WR_DWORD: begin
                if (!h0)
                    cmd.status = ST_FAULT;
                else if (!r_w[e0])
                    cmd.status = ST_NO_WRITE;
                else if (later_miss)
                    cmd.status = ST_FAULT;
                else
                    for (int k = 0; k < 4; k++)
                        cmd.we[k] = nmask[2'(k) - i_item.address[1:0]];
                if (i_item.op == OP_WR_BYTE && i_item.address == CONSOLE_ADDR) begin
                    cmd.cvalid = 1'b1;
                    cmd.cchar  = i_item.write_data[7:0];
                end
            end
            OP_MAP: begin
                if (!h0 && !hf)
                    cmd.status = ST_FULL;
            end
            default: ;
        endcase
        o_cmd = cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_fire) begin
            if (i_item.op == OP_MAP) begin
                if (h0) begin
                    r_w[e0] <= i_item.page_flags[0];
                    r_x[e0] <= i_item.page_flags[1];
                end else if (hf) begin
                    r_valid[ef] <= 1'b1;
                    r_pn[ef]    <= pn0;
                    r_w[ef]     <= i_item.page_flags[0];
                    r_x[ef]     <= i_item.page_flags[1];
                end
            end else if (i_item.op == OP_UNMAP) begin
                r_valid <= '0;
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/pmp_queue.sv
// two-entry queue of classified accesses between front and back
// depends on pmp_pkg
`default_nettype none

module pmp_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire pmp_pkg::t_cmd i_cmd,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_valid,
    output pmp_pkg::t_cmd      o_cmd
);
    import pmp_pkg::*;

    t_cmd       r_slot [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_slot[r_wp] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/pmp_back.sv
// back end: four byte banks, read assembly and result register
// depends on pmp_pkg
`default_nettype none

module pmp_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire pmp_pkg::t_cmd i_cmd,
    output logic               o_pop,
    output logic               o_valid,
    input  wire logic          i_ready,
    output pmp_pkg::t_out_item o_item
);
    import pmp_pkg::*;

    logic            r_out_valid;
    t_cmd            r_cmd;
    logic [3:0][7:0] r_q;
    logic [31:0]     data;

    assign o_pop = i_valid && (!r_out_valid || i_ready);

    for (genvar k = 0; k < 4; k++) begin : g_bank
        logic [7:0] mem [BANK_ROWS];
        always_ff @(posedge i_clk) begin
            if (o_pop && i_cmd.we[k]) mem[i_cmd.row[k]] <= i_cmd.wdata[k];
            if (o_pop && i_cmd.rd)    r_q[k] <= mem[i_cmd.row[k]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_cmd <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_out_valid <= 1'b0;
        else if (o_pop)
            r_out_valid <= 1'b1;
        else if (i_ready)
            r_out_valid <= 1'b0;
    end

    always_comb begin
        data = '0;
        for (int i = 0; i < 4; i++)
            if (r_cmd.rd && r_cmd.keep[i])
                data[8*i +: 8] = r_q[2'(i) + r_cmd.off];
        o_valid                 = r_out_valid;
        o_item.read_data        = data;
        o_item.status           = r_cmd.status;
        o_item.console_valid    = r_cmd.cvalid;
        o_item.console_char     = r_cmd.cchar;
        o_item.input_read_event = r_cmd.ievent;
    end

endmodule

`default_nettype wire

// File: hw/rtl/pmp_checker.sv
// port-level checks on the result channel of the protection unit
// depends on pmp_pkg, bound to paged_memory_with_permissions_core
`default_nettype none

module pmp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        i_ready,
    input wire logic [31:0] i_data,
    input wire logic [1:0]  i_status,
    input wire logic        i_cvalid,
    input wire logic [7:0]  i_cchar,
    input wire logic        i_ievent
);
    import pmp_pkg::*;

    a_no_out_after_reset: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_valid) else $error("result valid straight after reset");

    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_status != ST_OK |-> i_data == 32'd0) else $error("data on fault");

    a_char_needs_console: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_cvalid |-> i_cchar == 8'd0) else $error("stray console char");

    a_event_read_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_ievent |-> !i_cvalid && (i_status == ST_OK || i_status == ST_FAULT))
        else $error("input event on non-read");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_data) && $stable(i_status))
        else $error("stalled result changed");

endmodule

bind paged_memory_with_permissions_core pmp_checker u_pmp_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (o_out.valid),
    .i_ready  (o_out.ready),
    .i_data   (o_out.data.read_data),
    .i_status (o_out.data.status),
    .i_cvalid (o_out.data.console_valid),
    .i_cchar  (o_out.data.console_char),
    .i_ievent (o_out.data.input_read_event)
);

`default_nettype wire
